// File: hw/rtl/go_back_n_sender_macros.svh
// Assertion macros for the go-back-n sender checker.
// Both expect signals named clock and reset in scope.
`ifndef GO_BACK_N_SENDER_MACROS_SVH
`define GO_BACK_N_SENDER_MACROS_SVH

// Same-cycle implication.
`define GBN_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gbn assertion failed");

// Next-cycle implication.
`define GBN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gbn assertion failed");

`endif

// File: hw/rtl/gbn_pkg.sv
package gbn_pkg;

   localparam int SEQ_SPACE    = 8;
   localparam int PAYLOAD_BITS = 32;
   localparam int SEQ_BITS     = $clog2(SEQ_SPACE);
   localparam int WSIZE_BITS   = 3;
   localparam int OPCODE_BITS  = 2;
   localparam int KIND_BITS    = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int SUM_BITS     = SEQ_BITS + WSIZE_BITS;
   localparam int WRAP_STEPS   = (SEQ_SPACE - 1 + (2**WSIZE_BITS - 1)) / SEQ_SPACE;

   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(4);
   localparam logic [SEQ_BITS-1:0]   SEQ_RESET   = SEQ_BITS'(1 % SEQ_SPACE);

   localparam logic [OPCODE_BITS-1:0] OPC_SEND    = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OPC_ACK     = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OPC_TIMEOUT = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_REFUSED     = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_NEW         = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_RETX        = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_ACK_TAKEN   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_ACK_CORRUPT = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_TIMEOUT_IDLE = 3'd5;

   typedef enum logic [1:0] {
      CMD_SEND,
      CMD_ACK,
      CMD_TIMEOUT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type              op;
      logic [PAYLOAD_BITS-1:0] msg;
      logic [SEQ_BITS-1:0]     ackn;
      logic                    ack_ok;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   function automatic logic [SEQ_BITS-1:0] seq_inc(input logic [SEQ_BITS-1:0] x);
      logic [SEQ_BITS-1:0] r;
      if (x == SEQ_BITS'(SEQ_SPACE - 1)) r = '0;
      else r = x + SEQ_BITS'(1);
      return r;
   endfunction

   // (base + size) mod SEQ_SPACE, sum is small so a few subtracts suffice
   function automatic logic [SEQ_BITS-1:0] window_end(input logic [SEQ_BITS-1:0] base,
                                                      input logic [WSIZE_BITS-1:0] size);
      logic [SUM_BITS-1:0] s;
      s = SUM_BITS'(base) + SUM_BITS'(size);
      for (int k = 0; k < WRAP_STEPS; k++) begin
         if (s >= SUM_BITS'(SEQ_SPACE)) s = s - SUM_BITS'(SEQ_SPACE);
      end
      return s[SEQ_BITS-1:0];
   endfunction

endpackage

// File: hw/rtl/gbn_ram.sv
module gbn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gbn_front.sv
module gbn_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gbn_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [gbn_pkg::PAYLOAD_BITS-1:0]   req_message_word,
   input  logic [gbn_pkg::SEQ_BITS-1:0]       req_ack_number,
   input  logic                               req_ack_checksum_ok,
   output gbn_pkg::queue_head_type            head,
   input  logic                               pop
);

   localparam int PTR_BITS = (gbn_pkg::QUEUE_DEPTH > 1) ? $clog2(gbn_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(gbn_pkg::QUEUE_DEPTH + 1);

   gbn_pkg::cmd_type    entry_ff [gbn_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   gbn_pkg::cmd_type    cmd;
   logic                known;
   logic                push;
   logic                do_pop;

   function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (p == PTR_BITS'(gbn_pkg::QUEUE_DEPTH - 1)) r = '0;
      else r = p + PTR_BITS'(1);
      return r;
   endfunction

   // classify the command; unknown opcodes are dropped here
   always_comb begin
      cmd.msg    = req_message_word;
      cmd.ackn   = req_ack_number;
      cmd.ack_ok = req_ack_checksum_ok;
      cmd.op     = gbn_pkg::CMD_SEND;
      known      = 1'b1;
      unique case (req_opcode)
         gbn_pkg::OPC_SEND:    cmd.op = gbn_pkg::CMD_SEND;
         gbn_pkg::OPC_ACK:     cmd.op = gbn_pkg::CMD_ACK;
         gbn_pkg::OPC_TIMEOUT: cmd.op = gbn_pkg::CMD_TIMEOUT;
         default:              known  = 1'b0;
      endcase
   end

   assign busy   = (count_ff == CNT_BITS'(gbn_pkg::QUEUE_DEPTH));
   assign push   = start && !busy && known;
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push) - CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= cmd;
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

// File: hw/rtl/gbn_back.sv
module gbn_back (
   input  logic                               clock,
   input  logic                               reset,
   input  gbn_pkg::queue_head_type            head,
   output logic                               pop,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gbn_pkg::WSIZE_BITS-1:0]     csr_wdata,
   output logic                               rsp_valid,
   output logic [gbn_pkg::KIND_BITS-1:0]      rsp_kind,
   output logic [gbn_pkg::SEQ_BITS-1:0]       rsp_seq_out,
   output logic [gbn_pkg::PAYLOAD_BITS-1:0]   rsp_payload_out,
   output logic                               rsp_timer_start,
   output logic                               rsp_timer_stop,
   output logic                               rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   back_state_type                    state_ff, state_in;
   logic [gbn_pkg::SEQ_BITS-1:0]      base_ff, base_in;
   logic [gbn_pkg::SEQ_BITS-1:0]      next_ff, next_in;
   logic [gbn_pkg::WSIZE_BITS-1:0]    wsize_ff, wsize_in;
   logic [gbn_pkg::SEQ_BITS-1:0]      ptr_ff, ptr_in;
   logic                              first_ff, first_in;
   logic                              valid_ff, valid_in;
   logic [gbn_pkg::KIND_BITS-1:0]     kind_ff, kind_in;
   logic [gbn_pkg::SEQ_BITS-1:0]      seq_ff, seq_in;
   logic [gbn_pkg::PAYLOAD_BITS-1:0]  payload_ff, payload_in;
   logic                              tstart_ff, tstart_in;
   logic                              tstop_ff, tstop_in;
   logic                              last_ff, last_in;

   logic                              ram_we;
   logic                              ram_re;
   logic [gbn_pkg::PAYLOAD_BITS-1:0]  ram_rdata;
   logic [gbn_pkg::SEQ_BITS-1:0]      ack_base;

   gbn_ram #(
      .WIDTH (gbn_pkg::PAYLOAD_BITS),
      .DEPTH (gbn_pkg::SEQ_SPACE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (next_ff),
      .wr_data (head.cmd.msg),
      .rd_en   (ram_re),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   assign csr_ready = 1'b1;
   assign ack_base  = gbn_pkg::seq_inc(head.cmd.ackn);

   always_comb begin
      state_in   = state_ff;
      base_in    = base_ff;
      next_in    = next_ff;
      wsize_in   = (csr_valid && csr_ready) ? csr_wdata : wsize_ff;
      ptr_in     = ptr_ff;
      first_in   = first_ff;
      valid_in   = 1'b0;
      kind_in    = kind_ff;
      seq_in     = '0;
      payload_in = '0;
      tstart_in  = 1'b0;
      tstop_in   = 1'b0;
      last_in    = 1'b1;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               valid_in = 1'b1;
               unique case (head.cmd.op)
                  gbn_pkg::CMD_SEND: begin
                     if (gbn_pkg::window_end(base_ff, wsize_ff) == next_ff) begin
                        kind_in = gbn_pkg::KIND_REFUSED;
                     end else begin
                        ram_we     = 1'b1;
                        kind_in    = gbn_pkg::KIND_NEW;
                        seq_in     = next_ff;
                        payload_in = head.cmd.msg;
                        tstart_in  = (base_ff == next_ff);
                        next_in    = gbn_pkg::seq_inc(next_ff);
                     end
                  end
                  gbn_pkg::CMD_ACK: begin
                     if (!head.cmd.ack_ok) begin
                        kind_in = gbn_pkg::KIND_ACK_CORRUPT;
                     end else begin
                        kind_in   = gbn_pkg::KIND_ACK_TAKEN;
                        base_in   = ack_base;
                        tstart_in = (ack_base != next_ff);
                        tstop_in  = 1'b1;
                     end
                  end
                  gbn_pkg::CMD_TIMEOUT: begin
                     if (base_ff == next_ff) begin
                        kind_in   = gbn_pkg::KIND_TIMEOUT_IDLE;
                        tstart_in = 1'b1;
                        tstop_in  = 1'b1;
                     end else begin
                        valid_in = 1'b0;
                        ptr_in   = base_ff;
                        first_in = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  default: valid_in = 1'b0;
               endcase
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            valid_in   = 1'b1;
            kind_in    = gbn_pkg::KIND_RETX;
            seq_in     = ptr_ff;
            payload_in = ram_rdata;
            tstart_in  = first_ff;
            tstop_in   = first_ff;
            last_in    = (gbn_pkg::seq_inc(ptr_ff) == next_ff);
            first_in   = 1'b0;
            ptr_in     = gbn_pkg::seq_inc(ptr_ff);
            state_in   = last_in ? ST_IDLE : ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff  <= gbn_pkg::SEQ_RESET;
         next_ff  <= gbn_pkg::SEQ_RESET;
         wsize_ff <= gbn_pkg::WSIZE_RESET;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         next_ff  <= next_in;
         wsize_ff <= wsize_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      first_ff   <= first_in;
      kind_ff    <= kind_in;
      seq_ff     <= seq_in;
      payload_ff <= payload_in;
      tstart_ff  <= tstart_in;
      tstop_ff   <= tstop_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_seq_out     = seq_ff;
   assign rsp_payload_out = payload_ff;
   assign rsp_timer_start = tstart_ff;
   assign rsp_timer_stop  = tstop_ff;
   assign rsp_last        = last_ff;

endmodule

// File: hw/rtl/go_back_n_sender.sv
// Go-back-N sender. A command is registered in the command queue, and its result is then
// registered at the execute stage output. Send and ack each take one pass through the execute stage.
// Timeout: each resent packet takes a store read, then an emit.
// The receiver cannot stall; busy rises only when the 2-entry command queue is full.
// Synchronous reset: window base and next sequence 1, window size 4, store undefined.
module go_back_n_sender (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gbn_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [gbn_pkg::PAYLOAD_BITS-1:0]   req_message_word,
   input  logic [gbn_pkg::SEQ_BITS-1:0]       req_ack_number,
   input  logic                               req_ack_checksum_ok,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gbn_pkg::WSIZE_BITS-1:0]     csr_wdata,
   output logic                               rsp_valid,
   output logic [gbn_pkg::KIND_BITS-1:0]      rsp_kind,
   output logic [gbn_pkg::SEQ_BITS-1:0]       rsp_seq_out,
   output logic [gbn_pkg::PAYLOAD_BITS-1:0]   rsp_payload_out,
   output logic                               rsp_timer_start,
   output logic                               rsp_timer_stop,
   output logic                               rsp_last
);

   gbn_pkg::queue_head_type head;
   logic                    pop;

   gbn_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_message_word    (req_message_word),
      .req_ack_number      (req_ack_number),
      .req_ack_checksum_ok (req_ack_checksum_ok),
      .head                (head),
      .pop                 (pop)
   );

   gbn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_seq_out     (rsp_seq_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_timer_start (rsp_timer_start),
      .rsp_timer_stop  (rsp_timer_stop),
      .rsp_last        (rsp_last)
   );

endmodule

// File: hw/rtl/gbn_checker.sv
`include "go_back_n_sender_macros.svh"

module gbn_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic [gbn_pkg::KIND_BITS-1:0]    rsp_kind,
   input logic                             rsp_timer_start,
   input logic                             rsp_timer_stop,
   input logic                             rsp_last
);

   // only resent packets come in bursts
   `GBN_ASSERT(a_single_last, rsp_valid && rsp_kind != gbn_pkg::KIND_RETX, rsp_last)

   `GBN_ASSERT(a_corrupt_quiet, rsp_valid && rsp_kind == gbn_pkg::KIND_ACK_CORRUPT, !rsp_timer_start && !rsp_timer_stop)

   // each resent packet takes a store read, so rsp_valid is low right after a resent packet that is not the last
   `GBN_ASSERT_NEXT(a_retx_gap, rsp_valid && rsp_kind == gbn_pkg::KIND_RETX && !rsp_last, !rsp_valid)

   `GBN_ASSERT(a_retx_burst, rsp_valid && rsp_kind == gbn_pkg::KIND_RETX && !rsp_last, ##2 (rsp_valid && rsp_kind == gbn_pkg::KIND_RETX && !rsp_timer_start))

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_kind        (rsp_kind),
   .rsp_timer_start (rsp_timer_start),
   .rsp_timer_stop  (rsp_timer_stop),
   .rsp_last        (rsp_last)
);

// File: sim/tb_go_back_n_sender.sv
module tb_go_back_n_sender;
   import gbn_pkg::*;

   localparam logic [OPCODE_BITS-1:0] OPC_RESERVED = 2'd3;
   localparam int SEGMENTS       = 9;
   localparam int SEG_ITEMS      = 33;
   localparam int SETTLE_CYCLES  = 24;

   typedef struct packed {
      logic [KIND_BITS-1:0]    kind;
      logic [SEQ_BITS-1:0]     seq;
      logic [PAYLOAD_BITS-1:0] payload;
      logic                    tstart;
      logic                    tstop;
      logic                    last;
   } sender_emit_type;

   class gbn_window_tracker;
      logic [WSIZE_BITS-1:0]   wsize;
      logic [SEQ_BITS-1:0]     base_seq;
      logic [SEQ_BITS-1:0]     next_seq;
      logic [PAYLOAD_BITS-1:0] sent_payload [SEQ_SPACE];
      bit                      slot_written [SEQ_SPACE];
      sender_emit_type         due_emits [$];
      int                      failures;

      function new();
         wsize    = WSIZE_RESET;
         base_seq = SEQ_RESET;
         next_seq = SEQ_RESET;
         failures = 0;
         foreach (slot_written[i]) slot_written[i] = 0;
      endfunction

      function void push_emit(logic [KIND_BITS-1:0] kind, logic [SEQ_BITS-1:0] seq,
                              logic [PAYLOAD_BITS-1:0] payload, logic tstart,
                              logic tstop, logic last);
         sender_emit_type e;
         e.kind    = kind;
         e.seq     = seq;
         e.payload = payload;
         e.tstart  = tstart;
         e.tstop   = tstop;
         e.last    = last;
         due_emits.push_back(e);
      endfunction

      function int outstanding();
         return (int'(next_seq) - int'(base_seq) + SEQ_SPACE) % SEQ_SPACE;
      endfunction

      // a resend must never read a slot that was never filled
      function bit resend_allowed();
         int i;
         i = int'(base_seq);
         while (i != int'(next_seq)) begin
            if (!slot_written[i]) return 0;
            i = (i + 1) % SEQ_SPACE;
         end
         return 1;
      endfunction

      function void take_command(logic [OPCODE_BITS-1:0] op, logic [PAYLOAD_BITS-1:0] msg,
                                 logic [SEQ_BITS-1:0] ackn, logic ack_ok);
         int i;
         int nx;
         bit first;
         case (op)
            OPC_SEND: begin
               if ((int'(base_seq) + int'(wsize)) % SEQ_SPACE == int'(next_seq)) begin
                  push_emit(KIND_REFUSED, '0, '0, 1'b0, 1'b0, 1'b1);
               end else begin
                  sent_payload[next_seq] = msg;
                  slot_written[next_seq] = 1;
                  push_emit(KIND_NEW, next_seq, msg, base_seq == next_seq, 1'b0, 1'b1);
                  next_seq = SEQ_BITS'((int'(next_seq) + 1) % SEQ_SPACE);
               end
            end
            OPC_ACK: begin
               if (!ack_ok) begin
                  push_emit(KIND_ACK_CORRUPT, '0, '0, 1'b0, 1'b0, 1'b1);
               end else begin
                  base_seq = SEQ_BITS'((int'(ackn) + 1) % SEQ_SPACE);
                  push_emit(KIND_ACK_TAKEN, '0, '0, base_seq != next_seq, 1'b1, 1'b1);
               end
            end
            OPC_TIMEOUT: begin
               if (base_seq == next_seq) begin
                  push_emit(KIND_TIMEOUT_IDLE, '0, '0, 1'b1, 1'b1, 1'b1);
               end else begin
                  i = int'(base_seq);
                  first = 1;
                  while (i != int'(next_seq)) begin
                     nx = (i + 1) % SEQ_SPACE;
                     push_emit(KIND_RETX, SEQ_BITS'(i), sent_payload[i], first, first,
                               nx == int'(next_seq));
                     first = 0;
                     i = nx;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_emit(sender_emit_type got);
         sender_emit_type exp;
         if (due_emits.size() == 0) begin
            $error("unexpected result transfer: kind %0d seq %0d", got.kind, got.seq);
            failures++;
            return;
         end
         exp = due_emits.pop_front();
         if (got.kind !== exp.kind) begin
            $error("kind: expected %0d, got %0d", exp.kind, got.kind);
            failures++;
         end
         if (got.seq !== exp.seq) begin
            $error("seq_out: expected %0d, got %0d", exp.seq, got.seq);
            failures++;
         end
         if (got.payload !== exp.payload) begin
            $error("payload_out: expected %h, got %h", exp.payload, got.payload);
            failures++;
         end
         if (got.tstart !== exp.tstart) begin
            $error("timer_start: expected %0b, got %0b", exp.tstart, got.tstart);
            failures++;
         end
         if (got.tstop !== exp.tstop) begin
            $error("timer_stop: expected %0b, got %0b", exp.tstop, got.tstop);
            failures++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0b, got %0b", exp.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [OPCODE_BITS-1:0]  req_opcode = OPC_SEND;
   logic [PAYLOAD_BITS-1:0] req_message_word = '0;
   logic [SEQ_BITS-1:0]     req_ack_number = '0;
   logic                    req_ack_checksum_ok = 1'b0;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [WSIZE_BITS-1:0]   csr_wdata = '0;
   logic                    rsp_valid;
   logic [KIND_BITS-1:0]    rsp_kind;
   logic [SEQ_BITS-1:0]     rsp_seq_out;
   logic [PAYLOAD_BITS-1:0] rsp_payload_out;
   logic                    rsp_timer_start;
   logic                    rsp_timer_stop;
   logic                    rsp_last;

   gbn_window_tracker window_tracker = new();

   go_back_n_sender u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_message_word    (req_message_word),
      .req_ack_number      (req_ack_number),
      .req_ack_checksum_ok (req_ack_checksum_ok),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_seq_out         (rsp_seq_out),
      .rsp_payload_out     (rsp_payload_out),
      .rsp_timer_start     (rsp_timer_start),
      .rsp_timer_stop      (rsp_timer_stop),
      .rsp_last            (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // inputs only move at rising edges, so mid-cycle sampling is race free
   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         window_tracker.check_emit({rsp_kind, rsp_seq_out, rsp_payload_out,
                                    rsp_timer_start, rsp_timer_stop, rsp_last});
      end
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // called at a rising edge; returns at the edge where the transfer happens
   task automatic issue_cmd(input logic [OPCODE_BITS-1:0] op,
                            input logic [PAYLOAD_BITS-1:0] msg,
                            input logic [SEQ_BITS-1:0] ackn, input logic ack_ok,
                            input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start               <= 1'b1;
      req_opcode          <= op;
      req_message_word    <= msg;
      req_ack_number      <= ackn;
      req_ack_checksum_ok <= ack_ok;
      do @(negedge clock); while (busy);
      window_tracker.take_command(op, msg, ackn, ack_ok);
      @(posedge clock);
   endtask

   task automatic drain_and_settle();
      start <= 1'b0;
      while (window_tracker.due_emits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window_size(input logic [WSIZE_BITS-1:0] size);
      csr_valid <= 1'b1;
      csr_wdata <= size;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      window_tracker.wsize = size;
   endtask

   // returns 1 when the item can produce results
   task automatic random_cmd(input int idle_pct, output bit counted);
      int                      pick;
      int                      span;
      logic [OPCODE_BITS-1:0]  op;
      logic [PAYLOAD_BITS-1:0] msg;
      logic [SEQ_BITS-1:0]     ackn;
      logic                    ack_ok;
      pick   = $urandom_range(0, 99);
      msg    = $urandom;
      ackn   = SEQ_BITS'($urandom_range(0, SEQ_SPACE - 1));
      ack_ok = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) msg = $urandom_range(0, 1) ? '1 : '0;
      if (pick < 4) begin
         op = OPC_RESERVED;
      end else if (pick < 50) begin
         op = OPC_SEND;
      end else if (pick < 80) begin
         op     = OPC_ACK;
         ack_ok = ($urandom_range(0, 99) < 85);
         if ($urandom_range(0, 99) < 80) begin
            span = window_tracker.outstanding();
            ackn = SEQ_BITS'((int'(window_tracker.base_seq) + SEQ_SPACE - 1
                              + $urandom_range(0, span)) % SEQ_SPACE);
         end
      end else begin
         op = window_tracker.resend_allowed() ? OPC_TIMEOUT : OPC_SEND;
      end
      issue_cmd(op, msg, ackn, ack_ok, idle_pct);
      counted = (op != OPC_RESERVED);
   endtask

   initial begin
      logic [WSIZE_BITS-1:0] seg_wsize [SEGMENTS];
      int                    idle_pct;
      int                    done_items;
      bit                    counted;

      seg_wsize = '{3'd7, 3'd1, 3'd5, 3'd2, 3'd6, 3'd1, 3'd3, 3'd7, 3'd4};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, window size 4 from reset
      issue_cmd(OPC_TIMEOUT, '0, '0, 1'b0, 22);
      issue_cmd(OPC_ACK, '0, 3'd7, 1'b0, 22);
      issue_cmd(OPC_SEND, 32'h0000_0000, 3'd7, 1'b1, 22);
      issue_cmd(OPC_SEND, 32'hFFFF_FFFF, 3'd0, 1'b0, 22);
      issue_cmd(OPC_SEND, 32'hA5A5_A5A5, 3'd5, 1'b1, 22);
      issue_cmd(OPC_SEND, 32'h5A5A_5A5A, 3'd2, 1'b0, 22);
      issue_cmd(OPC_SEND, 32'h1234_5678, 3'd0, 1'b0, 22);
      issue_cmd(OPC_RESERVED, 32'hFFFF_FFFF, 3'd7, 1'b1, 22);
      issue_cmd(OPC_TIMEOUT, '0, '0, 1'b0, 22);
      issue_cmd(OPC_ACK, '0, 3'd0, 1'b0, 22);
      issue_cmd(OPC_ACK, '0, 3'd2, 1'b1, 22);
      issue_cmd(OPC_TIMEOUT, '0, '0, 1'b0, 22);
      issue_cmd(OPC_ACK, '0, 3'd4, 1'b1, 22);
      // good ack behind the window pulls the base back
      issue_cmd(OPC_ACK, '0, 3'd0, 1'b1, 22);
      issue_cmd(OPC_TIMEOUT, '0, '0, 1'b0, 22);
      issue_cmd(OPC_ACK, '0, 3'd4, 1'b1, 22);
      issue_cmd(OPC_SEND, 32'hDEAD_BEEF, 3'd0, 1'b0, 22);
      issue_cmd(OPC_SEND, 32'h0F0F_0F0F, 3'd0, 1'b0, 22);
      issue_cmd(OPC_SEND, 32'hF0F0_F0F0, 3'd0, 1'b0, 22);
      issue_cmd(OPC_SEND, 32'h8000_0001, 3'd0, 1'b0, 22);
      issue_cmd(OPC_SEND, 32'h7FFF_FFFE, 3'd0, 1'b0, 22);
      issue_cmd(OPC_TIMEOUT, '0, '0, 1'b0, 22);
      issue_cmd(OPC_ACK, '0, 3'd7, 1'b1, 22);
      issue_cmd(OPC_TIMEOUT, '0, '0, 1'b0, 22);
      issue_cmd(OPC_ACK, '0, 3'd0, 1'b1, 22);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_and_settle();
         write_window_size(seg_wsize[seg]);
         idle_pct   = (seg < 3) ? 22 : ((seg < 6) ? 68 : 0);
         done_items = 0;
         while (done_items < SEG_ITEMS) begin
            random_cmd(idle_pct, counted);
            if (counted) done_items++;
         end
      end

      drain_and_settle();
      if (window_tracker.failures == 0 && window_tracker.due_emits.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_ram.sv
hw/rtl/gbn_front.sv
hw/rtl/gbn_back.sv
hw/rtl/go_back_n_sender.sv
hw/rtl/gbn_checker.sv
sim/tb_go_back_n_sender.sv
